FILE: sv/lirs_pkg.sv
package lirs_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int OUT_PER_BLK = 2048;
    localparam int FRAC_W      = 11;
    localparam int OIDX_W      = 12;
    localparam int IIDX_W      = 13;
    localparam int BLK_W       = 14;
    localparam int ACC_W       = 25;
    localparam int CNT_W       = 6;
    localparam int MIN_BLOCK   = 32;
    localparam int MAX_BLOCK   = 8192;
    localparam int MAX_RUN     = 64;
    localparam int BLK_RESET   = 2048;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] in_i;
        logic signed [SAMPLE_W-1:0] in_q;
    } in_word_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] out_i;
        logic signed [SAMPLE_W-1:0] out_q;
        logic                       run_last;
        logic                       block_end;
    } out_word_t;

    // One accepted input, classified by the front end
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] prev_i;
        logic signed [SAMPLE_W-1:0] prev_q;
        logic signed [SAMPLE_W-1:0] cur_i;
        logic signed [SAMPLE_W-1:0] cur_q;
        logic [IIDX_W-1:0]          in_idx;
        logic                       block_last;
    } job_t;

    // Block size control from the front end to the back end
    typedef struct packed {
        logic [BLK_W-1:0] blk_size;
        logic             recalc;
    } blk_ctrl_t;

endpackage

FILE: sv/lirs_fifo.sv
module lirs_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  lirs_pkg::job_t push_data,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output lirs_pkg::job_t pop_data
);
    import lirs_pkg::*;

    localparam int DEPTH = 4;
    localparam int PTR_W = $clog2(DEPTH);

    job_t             mem [DEPTH];
    logic [PTR_W-1:0] wptr_reg;
    logic [PTR_W-1:0] rptr_reg;
    logic [PTR_W:0]   count_reg;
    logic [PTR_W:0]   count_next;

    assign full      = (count_reg == (PTR_W+1)'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem[rptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (push) begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop) begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

FILE: sv/lirs_front.sv
module lirs_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  lirs_pkg::in_word_t  s_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [13:0]         cfg_data,
    output logic                job_push,
    output lirs_pkg::job_t      job_data,
    input  logic                job_full,
    output lirs_pkg::blk_ctrl_t ctrl
);
    import lirs_pkg::*;

    logic signed [SAMPLE_W-1:0] prev_i_reg;
    logic signed [SAMPLE_W-1:0] prev_q_reg;
    logic [IIDX_W-1:0]          in_idx_reg;
    logic [BLK_W-1:0]           blk_reg;
    logic [BLK_W-1:0]           blk_next;
    logic                       accept;
    logic                       block_last;

    assign cfg_ready = 1'b1;
    assign s_ready   = !job_full;
    assign accept    = s_valid && s_ready;

    // Clamp the block size into its legal range on write
    always_comb begin
        priority if (cfg_data < BLK_W'(MIN_BLOCK)) begin
            blk_next = BLK_W'(MIN_BLOCK);
        end else if (cfg_data > BLK_W'(MAX_BLOCK)) begin
            blk_next = BLK_W'(MAX_BLOCK);
        end else begin
            blk_next = cfg_data;
        end
    end

    assign block_last = ({1'b0, in_idx_reg} >= (blk_reg - 1'b1));

    assign job_push            = accept;
    assign job_data.prev_i     = prev_i_reg;
    assign job_data.prev_q     = prev_q_reg;
    assign job_data.cur_i      = s_data.in_i;
    assign job_data.cur_q      = s_data.in_q;
    assign job_data.in_idx     = in_idx_reg;
    assign job_data.block_last = block_last;

    assign ctrl.blk_size = blk_reg;
    assign ctrl.recalc   = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_i_reg <= '0;
            prev_q_reg <= '0;
            in_idx_reg <= '0;
            blk_reg    <= BLK_W'(BLK_RESET);
        end else begin
            if (cfg_valid && cfg_ready) begin
                blk_reg <= blk_next;
            end
            if (accept) begin
                prev_i_reg <= s_data.in_i;
                prev_q_reg <= s_data.in_q;
                in_idx_reg <= block_last ? '0 : in_idx_reg + 1'b1;
            end
        end
    end

endmodule

FILE: sv/lirs_back.sv
module lirs_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                job_valid,
    input  lirs_pkg::job_t      job,
    output logic                job_pop,
    input  lirs_pkg::blk_ctrl_t ctrl,
    output logic                m_valid,
    input  logic                m_ready,
    output lirs_pkg::out_word_t m_data
);
    import lirs_pkg::*;

    localparam logic [OIDX_W-1:0] OI_END  = OIDX_W'(OUT_PER_BLK);
    localparam logic [OIDX_W-1:0] OI_LAST = OIDX_W'(OUT_PER_BLK - 1);
    localparam logic [CNT_W-1:0]  CNT_TOP = CNT_W'(MAX_RUN - 1);
    localparam int                POS_W   = ACC_W - FRAC_W;
    localparam int                PROD_W  = SAMPLE_W + 1 + FRAC_W + 1;

    // Position state
    logic [OIDX_W-1:0] oi_reg, oi_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              stale_reg, stale_next;

    logic [ACC_W-1:0]        acc_step;
    logic [OIDX_W+BLK_W-1:0] acc_prod;
    logic [POS_W-1:0]        idx_ext;
    logic                    cond, next_cond, step, emit, en;

    // Interpolation stage
    logic                       s1_valid_reg;
    logic signed [SAMPLE_W-1:0] s1_prev_i_reg, s1_prev_q_reg;
    logic signed [SAMPLE_W:0]   s1_diff_i_reg, s1_diff_q_reg;
    logic [FRAC_W-1:0]          s1_frac_reg;
    logic                       s1_run_last_reg, s1_block_end_reg;

    logic signed [SAMPLE_W:0]   diff_i, diff_q;
    logic signed [PROD_W-1:0]   sum_i, sum_q;

    logic      m_valid_reg;
    out_word_t m_data_reg;

    assign en       = !m_valid_reg || m_ready;
    assign acc_step = acc_reg + ACC_W'(ctrl.blk_size);
    assign acc_prod = oi_reg * ctrl.blk_size;
    assign idx_ext  = POS_W'(job.in_idx);

    assign cond      = (oi_reg < OI_END) && (acc_reg[ACC_W-1:FRAC_W] <= idx_ext);
    assign next_cond = (oi_reg != OI_LAST) && (acc_step[ACC_W-1:FRAC_W] <= idx_ext)
                       && (cnt_reg != CNT_TOP);

    // A job with no output retires at once; one with outputs waits for space
    assign step    = job_valid && !stale_reg && (en || !cond);
    assign emit    = step && cond;
    assign job_pop = step && (!cond || !next_cond);

    always_comb begin
        oi_next    = oi_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        stale_next = stale_reg;
        if (ctrl.recalc) begin
            stale_next = 1'b1;
        end else if (stale_reg) begin
            acc_next   = acc_prod[ACC_W-1:0];
            stale_next = 1'b0;
        end else begin
            if (emit) begin
                oi_next  = oi_reg + 1'b1;
                acc_next = acc_step;
                cnt_next = cnt_reg + 1'b1;
            end
            if (job_pop) begin
                cnt_next = '0;
                if (job.block_last) begin
                    oi_next  = '0;
                    acc_next = '0;
                end
            end
        end
    end

    assign diff_i = {job.cur_i[SAMPLE_W-1], job.cur_i} - {job.prev_i[SAMPLE_W-1], job.prev_i};
    assign diff_q = {job.cur_q[SAMPLE_W-1], job.cur_q} - {job.prev_q[SAMPLE_W-1], job.prev_q};

    // prev*2^11 + (cur-prev)*frac, floored by dropping the fraction bits
    assign sum_i = PROD_W'($signed({s1_prev_i_reg, {FRAC_W{1'b0}}}))
                   + s1_diff_i_reg * $signed({1'b0, s1_frac_reg});
    assign sum_q = PROD_W'($signed({s1_prev_q_reg, {FRAC_W{1'b0}}}))
                   + s1_diff_q_reg * $signed({1'b0, s1_frac_reg});

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_prev_i_reg    <= job.prev_i;
            s1_prev_q_reg    <= job.prev_q;
            s1_diff_i_reg    <= diff_i;
            s1_diff_q_reg    <= diff_q;
            s1_frac_reg      <= acc_reg[FRAC_W-1:0];
            s1_run_last_reg  <= !next_cond;
            s1_block_end_reg <= (oi_reg == OI_LAST);
            m_data_reg.out_i     <= sum_i[SAMPLE_W+FRAC_W-1:FRAC_W];
            m_data_reg.out_q     <= sum_q[SAMPLE_W+FRAC_W-1:FRAC_W];
            m_data_reg.run_last  <= s1_run_last_reg;
            m_data_reg.block_end <= s1_block_end_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            oi_reg       <= '0;
            acc_reg      <= '0;
            cnt_reg      <= '0;
            stale_reg    <= 1'b0;
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            oi_reg    <= oi_next;
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
            stale_reg <= stale_next;
            if (en) begin
                s1_valid_reg <= emit;
                m_valid_reg  <= s1_valid_reg;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

FILE: sv/linear_interp_block_resampler.sv
// Channel   Ports                           Word
// input     s_valid  s_ready  s_data        in_word_t  (in_i, in_q)
// result    m_valid  m_ready  m_data        out_word_t (out_i, out_q, run_last, block_end)
// config    cfg_valid cfg_ready cfg_data    14-bit block size, always ready
//
// An input word holds the back end while the result words it causes go out (one at
// the default block size); the back end's single interpolation path gives one result
// word per cycle unless m_ready stalls it. After accept a word passes the queue, the
// interpolation stage and the output register. A config write pauses the back end while
// its position accumulator is rebuilt. Reset is synchronous on aresetn low; m_ready low
// holds the result pipeline while the front end keeps filling its four-entry queue.
module linear_interp_block_resampler (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  lirs_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output lirs_pkg::out_word_t m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [13:0]         cfg_data
);
    import lirs_pkg::*;

    // Front end to queue
    logic      push;
    job_t      push_data;
    logic      full;

    // Queue to back end
    logic      pop;
    logic      not_empty;
    job_t      head;

    blk_ctrl_t ctrl;

    // Accept, number and pair each input word with its predecessor
    lirs_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .job_push  (push),
        .job_data  (push_data),
        .job_full  (full),
        .ctrl      (ctrl)
    );

    // Decouple input acceptance from output expansion
    lirs_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .not_empty (not_empty),
        .pop_data  (head)
    );

    // Walk the output positions and blend each pair of samples
    lirs_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .job_valid (not_empty),
        .job       (head),
        .job_pop   (pop),
        .ctrl      (ctrl),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import lirs_pkg::*;

    localparam int CLK_PERIOD    = 20;
    localparam int RESET_CYCLES  = 10;
    // Results pass the queue, the interpolation stage and the output register after accept;
    // a four-word queue in front may still hold samples that cause no result, so allow for all of them.
    localparam int SETTLE_CYCLES = 24;
    localparam int IDLE_PCT      = 16;
    localparam longint RUN_LIMIT_NS = 64'd400_000 * CLK_PERIOD;

    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             s_valid   = 1'b0;
    logic             s_ready;
    in_word_t         s_data    = '0;
    logic             m_valid;
    logic             m_ready   = 1'b0;
    out_word_t        m_data;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [BLK_W-1:0] cfg_data  = '0;

    // Interpolator state as the block should hold it
    logic [BLK_W-1:0]     blk_size_reg = BLK_W'(BLK_RESET);
    logic signed [15:0]   last_i       = '0;
    logic signed [15:0]   last_q       = '0;
    int unsigned          sample_idx   = 0;
    int unsigned          interp_idx   = 0;

    out_word_t            pending_outputs[$];
    int unsigned          mismatch_count = 0;
    bit                   steady         = 1'b0;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    linear_interp_block_resampler u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Print one line per mismatch and count every one.
    task automatic report_mismatch(input string what, input int want, input int got);
        mismatch_count++;
        $display("MISMATCH %0s: expected %0d, got %0d at %0t ns", what, want, got, $time);
    endtask

    // Floor of (prev*(2048-f) + cur*f) / 2048; the arithmetic shift floors negatives.
    function automatic logic signed [15:0] blend_sample(input logic signed [15:0] prev,
                                                       input logic signed [15:0] cur,
                                                       input int unsigned frac);
        longint p;
        longint c;
        longint f;
        longint num;
        p   = prev;
        c   = cur;
        f   = frac;
        num = p * (OUT_PER_BLK - f) + c * f;
        num = num >>> FRAC_W;
        return num[15:0];
    endfunction

    // Work out every result word this sample causes and queue them in order.
    function automatic void predict_interp(input in_word_t w);
        int unsigned n;
        int unsigned pos;
        int unsigned run;
        out_word_t   o;
        n = blk_size_reg;
        if (n < MIN_BLOCK) n = MIN_BLOCK;
        if (n > MAX_BLOCK) n = MAX_BLOCK;
        run = 0;
        pos = interp_idx * n;
        while (run < MAX_RUN && interp_idx < OUT_PER_BLK && pos / OUT_PER_BLK <= sample_idx) begin
            o.out_i     = blend_sample(last_i, w.in_i, pos % OUT_PER_BLK);
            o.out_q     = blend_sample(last_q, w.in_q, pos % OUT_PER_BLK);
            o.run_last  = 1'b0;
            o.block_end = (interp_idx == OUT_PER_BLK - 1);
            pending_outputs.push_back(o);
            run++;
            interp_idx++;
            pos += n;
        end
        // Mark the last word of this sample's run
        if (run > 0) begin
            o = pending_outputs[pending_outputs.size() - 1];
            o.run_last = 1'b1;
            pending_outputs[pending_outputs.size() - 1] = o;
        end
        last_i = w.in_i;
        last_q = w.in_q;
        // The sample at index n-1 or beyond closes the block; drop what is left.
        if (sample_idx >= n - 1) begin
            sample_idx = 0;
            interp_idx = 0;
        end else begin
            sample_idx++;
        end
    endfunction

    // Present one sample word, idle now and then first, and predict on accept.
    // Valid is left high; an idle before the next word or a drain lowers it.
    task automatic send_sample(input in_word_t w);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        predict_interp(w);
    endtask

    // Drop valid, wait for every pending result word, then let the pipeline settle.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_outputs.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Write the block size, only with the block idle.
    task automatic write_block_size(input logic [BLK_W-1:0] n);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= n;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        blk_size_reg = n;
    endtask

    // Random sample, often with a full-scale or near-zero component.
    function automatic in_word_t rand_sample();
        in_word_t    w;
        logic [15:0] corner[5];
        corner = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF, 16'h0001};
        w = in_word_t'($urandom);
        if ($urandom_range(0, 9) < 3) w.in_i = corner[$urandom_range(0, 4)];
        if ($urandom_range(0, 9) < 3) w.in_q = corner[$urandom_range(0, 4)];
        return w;
    endfunction

    // Reset block size: one result per sample, equal to the previous sample.
    // Walk both fields through their extremes; the first result must be zero.
    task automatic test_default_size_corners();
        send_sample({16'h0000, 16'h0000});
        send_sample({16'h7FFF, 16'h8000});
        send_sample({16'h8000, 16'h7FFF});
        send_sample({16'hFFFF, 16'h0001});
        send_sample({16'h7FFF, 16'h7FFF});
        send_sample({16'h8000, 16'h8000});
        send_sample({16'h5555, 16'hAAAA});
        send_sample({16'hAAAA, 16'h5555});
    endtask

    // Block size at both ends and clamped beyond them, each change mid-block.
    task automatic test_size_extremes();
        // Smallest block: 64 words per sample and a backlog that spills over
        write_block_size(BLK_W'(MIN_BLOCK));
        send_sample({16'h7FFF, 16'h8000});
        send_sample({16'h8000, 16'h7FFF});
        send_sample({16'h7FFF, 16'h7FFF});
        send_sample({16'h8000, 16'h8000});
        send_sample({16'hFFFF, 16'h0000});
        send_sample({16'h0001, 16'hFFFF});
        send_sample({16'h7FFF, 16'h8000});
        send_sample({16'h8000, 16'h7FFF});
        // Field maximum clamps to the largest block: most samples cause nothing
        write_block_size(14'h3FFF);
        send_sample({16'h8000, 16'h7FFF});
        send_sample({16'h7FFF, 16'h8000});
        send_sample({16'h0000, 16'hFFFF});
        send_sample({16'h7FFF, 16'h7FFF});
        send_sample({16'h8000, 16'h8000});
        // Zero clamps to the smallest block again
        write_block_size('0);
        send_sample({16'h7FFF, 16'h8000});
        send_sample({16'h8000, 16'h7FFF});
        send_sample({16'h1234, 16'hEDCB});
        send_sample({16'hFFFF, 16'hFFFF});
    endtask

    // Small blocks end often: cover block_end, the index wrap and the carried sample.
    task automatic test_whole_blocks();
        write_block_size(BLK_W'(MIN_BLOCK));
        repeat (64) send_sample(rand_sample());
        write_block_size(BLK_W'(MIN_BLOCK - 1));
        repeat (40) send_sample(rand_sample());
        // Ratio with a fraction that does not repeat every sample
        write_block_size(BLK_W'(40));
        repeat (45) send_sample(rand_sample());
    endtask

    // Full rate with no idling on either side.
    task automatic test_full_rate();
        write_block_size(BLK_W'(BLK_RESET));
        steady = 1'b1;
        repeat (40) send_sample(rand_sample());
        wait_drained();
        steady = 1'b0;
    endtask

    // Hold the sender until every result is out, then resume mid-block.
    task automatic test_pause_for_drain();
        write_block_size(BLK_W'(1000));
        repeat (10) send_sample(rand_sample());
        wait_drained();
        repeat (10) send_sample(rand_sample());
    endtask

    // Bursts of random samples between random block sizes, mostly small ones.
    task automatic test_random_sizes(input int unsigned n_items);
        int unsigned      sent;
        int unsigned      burst;
        logic [BLK_W-1:0] sz;
        sent = 0;
        while (sent < n_items) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: begin
                    sz = BLK_W'($urandom_range(MIN_BLOCK, 96));
                end
                6, 7: begin
                    sz = BLK_W'($urandom_range(97, 4096));
                end
                8: begin
                    sz = BLK_W'($urandom_range(0, 1) ? $urandom_range(0, MIN_BLOCK - 1)
                                                     : $urandom_range(MAX_BLOCK + 1, 16383));
                end
                default: begin
                    sz = BLK_W'($urandom_range(0, 1) ? MAX_BLOCK : BLK_RESET);
                end
            endcase
            write_block_size(sz);
            burst = $urandom_range(5, 30);
            repeat (burst) send_sample(rand_sample());
            sent += burst;
        end
    endtask

    // Receiver: stall at random unless the steady stretch is on.
    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // Compare each accepted result word with the oldest pending one.
    always @(posedge aclk) begin
        out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_outputs.size() == 0) begin
                report_mismatch("result word with nothing pending", 0, int'(m_data));
            end else begin
                want = pending_outputs.pop_front();
                if (m_data.out_i !== want.out_i)
                    report_mismatch("out_i", want.out_i, m_data.out_i);
                if (m_data.out_q !== want.out_q)
                    report_mismatch("out_q", want.out_q, m_data.out_q);
                if (m_data.run_last !== want.run_last)
                    report_mismatch("run_last", want.run_last, m_data.run_last);
                if (m_data.block_end !== want.block_end)
                    report_mismatch("block_end", want.block_end, m_data.block_end);
            end
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_default_size_corners();
        test_size_extremes();
        test_whole_blocks();
        test_full_rate();
        test_pause_for_drain();
        test_random_sizes(130);

        // Drain and settle; a stray word in the settle window counts as a mismatch
        wait_drained();
        if (mismatch_count == 0 && pending_outputs.size() == 0) begin
            $display("** linear_interp_block_resampler: PASSED **");
        end else begin
            $display("** linear_interp_block_resampler: FAILED **");
        end
        $finish;
    end

    // Hang guard
    initial begin
        #(RUN_LIMIT_NS);
        $display("** linear_interp_block_resampler: FAILED **");
        $finish;
    end

endmodule
